### design/ascii_command_frame_decoder_assert.svh
// Assertion macros shared by the checker of the ASCII command frame decoder.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASCII_COMMAND_FRAME_DECODER_ASSERT_SVH
`define ASCII_COMMAND_FRAME_DECODER_ASSERT_SVH

// Plain clocked assertion, switched off while reset is active.
`define ACFD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled request keeps its valid and its payload until it is taken.
`define ACFD_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
	`ACFD_ASSERT(label, clk, rst_n, vld && !rdy |=> vld && $stable(sig), msg)

`endif

### design/acfd_pkg.sv
// Shared types, character codes and tag table of the ASCII command frame decoder.
// Depends on nothing; every other design file except the assertion header uses it by scoped names.
`timescale 1ns / 1ps

package acfd_pkg;

	// Frame geometry.
	localparam int HEADER_LENGTH = 3;
	localparam int FIELD_COUNT   = 4;
	localparam int NUM_VALUES    = 4;
	localparam int NUM_TAGS      = 6;

	typedef logic [7:0] char_t;
	typedef logic [2:0] comma_cnt_t;

	localparam comma_cnt_t COMMA_MAX     = 3'd7;
	localparam comma_cnt_t COMMA_EXPECT  = 3'(FIELD_COUNT - 1);

	// Characters the parser looks for.
	localparam char_t CHAR_DOLLAR = 8'h24;
	localparam char_t CHAR_C      = 8'h43;
	localparam char_t CHAR_M      = 8'h4D;
	localparam char_t CHAR_CR     = 8'h0D;
	localparam char_t CHAR_LF     = 8'h0A;
	localparam char_t CHAR_ONE    = 8'h31;
	localparam char_t CHAR_ZERO   = 8'h30;
	localparam char_t CHAR_NINE   = 8'h39;
	localparam char_t CHAR_COMMA  = 8'h2C;

	typedef enum logic [2:0] {
		CMD_TAKE_OFF,
		CMD_THROTTLE,
		CMD_HEIGHT,
		CMD_LOG,
		CMD_KEEP_ALIVE,
		CMD_ATTITUDE
	} cmd_t;

	// Tag bytes, first received byte at index 0.
	typedef logic [HEADER_LENGTH-1:0][7:0] tag_t;

	localparam tag_t TAG_TABLE [NUM_TAGS] = '{
		{"K", "A", "T"},
		{"R", "H", "T"},
		{"T", "E", "H"},
		{"G", "O", "L"},
		{"P", "E", "K"},
		{"L", "T", "C"}
	};

	typedef struct packed {
		logic hit;
		cmd_t code;
	} tag_match_t;

	// Field control from the frame sequencer to the accumulators.
	typedef struct packed {
		logic frame_start;
		logic digit_en;
		logic comma_en;
	} field_ctl_t;

	typedef logic signed [15:0] value_t;

	// One decoded command, as held in the output register.
	typedef struct packed {
		cmd_t   command;
		logic   arg_is_one;
		value_t roll_value;
		value_t pitch_value;
		value_t yaw_value;
		value_t thrust_value;
		logic   fields_valid;
	} result_t;

	// Look a tag up in the table; the entries are distinct, so at most one hits.
	function automatic tag_match_t tag_lookup(input tag_t tag);
		tag_match_t m;
		m.hit  = 1'b0;
		m.code = CMD_TAKE_OFF;
		for (int k = 0; k < NUM_TAGS; k++) begin
			if (tag == TAG_TABLE[k]) begin
				m.hit  = 1'b1;
				m.code = cmd_t'(3'(k));
			end
		end
		return m;
	endfunction

endpackage

### design/acfd_channels_if.sv
// Valid/ready channel interfaces of the ASCII command frame decoder.
// Depends on acfd_pkg for the payload types.
`timescale 1ns / 1ps

// Received byte channel.
interface acfd_rx_if;
	logic          valid;
	logic          ready;
	acfd_pkg::char_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded command channel.
interface acfd_cmd_if;
	logic             valid;
	logic             ready;
	logic [2:0]       command;
	logic             arg_is_one;
	acfd_pkg::value_t roll_value;
	acfd_pkg::value_t pitch_value;
	acfd_pkg::value_t yaw_value;
	acfd_pkg::value_t thrust_value;
	logic             fields_valid;

	modport source (
		output valid, output command, output arg_is_one, output roll_value,
		output pitch_value, output yaw_value, output thrust_value,
		output fields_valid, input ready
	);
	modport sink (
		input valid, input command, input arg_is_one, input roll_value,
		input pitch_value, input yaw_value, input thrust_value,
		input fields_valid, output ready
	);
endinterface

### design/acfd_frame_ctl.sv
// Frame sequencer: header match, tag capture, first payload byte and frame end.
// Depends on acfd_pkg; drives the field accumulators through a field_ctl_t.
`timescale 1ns / 1ps

module acfd_frame_ctl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  acfd_pkg::char_t      rx_byte,
	output acfd_pkg::field_ctl_t field_ctl,
	output logic                 done,
	output acfd_pkg::cmd_t       command,
	output logic                 arg_is_one
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DOLLAR,
		ST_GOT_C,
		ST_TAG0,
		ST_TAG1,
		ST_TAG2,
		ST_PAYLOAD
	} stage_t;

	stage_t               stage_q;
	acfd_pkg::tag_t       tag_q;
	acfd_pkg::char_t      first_q;
	logic                 seen_q;
	logic                 saw_cr_q;
	logic                 pdone_q;

	logic                 is_cr;
	logic                 is_lf;
	logic                 is_dollar;
	logic                 is_digit;
	logic                 is_comma;
	logic                 in_idle;
	logic                 in_payload;
	logic                 frame_end;
	logic [1:0]           tag_idx;
	acfd_pkg::tag_match_t match;

	// Byte classes.
	assign is_cr     = (rx_byte == acfd_pkg::CHAR_CR);
	assign is_lf     = (rx_byte == acfd_pkg::CHAR_LF);
	assign is_dollar = (rx_byte == acfd_pkg::CHAR_DOLLAR);
	assign is_comma  = (rx_byte == acfd_pkg::CHAR_COMMA);
	assign is_digit  = (rx_byte >= acfd_pkg::CHAR_ZERO) && (rx_byte <= acfd_pkg::CHAR_NINE);

	// Stage decode; any stage outside the header, tag and payload waits for a dollar.
	always_comb begin
		in_idle    = 1'b0;
		in_payload = 1'b0;
		tag_idx    = 2'd0;
		unique case (stage_q)
			ST_DOLLAR, ST_GOT_C: begin
			end
			ST_TAG0: tag_idx = 2'd0;
			ST_TAG1: tag_idx = 2'd1;
			ST_TAG2: tag_idx = 2'd2;
			ST_PAYLOAD: in_payload = 1'b1;
			default: in_idle = 1'b1;
		endcase
	end

	// A CR LF pair in the payload closes the frame.
	assign frame_end = fire && in_payload && saw_cr_q && is_lf;

	// Digits and commas count only before the first CR of the payload.
	assign field_ctl.frame_start = fire && in_idle && is_dollar;
	assign field_ctl.digit_en    = fire && in_payload && !frame_end && !is_cr && !pdone_q
		&& is_digit;
	assign field_ctl.comma_en    = fire && in_payload && !frame_end && !is_cr && !pdone_q
		&& is_comma;

	// Result of a closing frame.
	assign match      = acfd_pkg::tag_lookup(tag_q);
	assign done       = frame_end && match.hit;
	assign command    = match.code;
	assign arg_is_one = seen_q && (first_q == acfd_pkg::CHAR_ONE);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= ST_IDLE;
			tag_q    <= '0;
			first_q  <= '0;
			seen_q   <= 1'b0;
			saw_cr_q <= 1'b0;
			pdone_q  <= 1'b0;
		end else if (fire) begin
			unique case (stage_q)
				ST_DOLLAR: begin
					stage_q <= (rx_byte == acfd_pkg::CHAR_C) ? ST_GOT_C
						: (is_dollar ? ST_DOLLAR : ST_IDLE);
				end
				ST_GOT_C: begin
					stage_q <= (rx_byte == acfd_pkg::CHAR_M) ? ST_TAG0
						: (is_dollar ? ST_DOLLAR : ST_IDLE);
				end
				ST_TAG0, ST_TAG1, ST_TAG2: begin
					if (saw_cr_q && is_lf) begin
						stage_q <= ST_IDLE;
					end else begin
						tag_q[tag_idx] <= rx_byte;
						saw_cr_q       <= is_cr;
						stage_q        <= stage_t'(3'(stage_q) + 3'd1);
					end
				end
				ST_PAYLOAD: begin
					if (frame_end) begin
						stage_q <= ST_IDLE;
					end else begin
						if (!seen_q) begin
							first_q <= rx_byte;
							seen_q  <= 1'b1;
						end
						if (is_cr) begin
							pdone_q <= 1'b1;
						end
						saw_cr_q <= is_cr;
					end
				end
				default: begin
					if (is_dollar) begin
						tag_q    <= '0;
						first_q  <= '0;
						seen_q   <= 1'b0;
						saw_cr_q <= 1'b0;
						pdone_q  <= 1'b0;
						stage_q  <= ST_DOLLAR;
					end else begin
						stage_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

### design/acfd_fields.sv
// Decimal field accumulators and comma counter of an attitude frame.
// Depends on acfd_pkg; controlled by acfd_frame_ctl through a field_ctl_t.
`timescale 1ns / 1ps

module acfd_fields (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  acfd_pkg::field_ctl_t                      field_ctl,
	input  logic [3:0]                                digit,
	output logic [acfd_pkg::NUM_VALUES-1:0][15:0]     values,
	output logic                                      fields_valid
);

	logic [15:0]          acc_q [acfd_pkg::FIELD_COUNT];
	acfd_pkg::comma_cnt_t comma_q;

	// Comma count saturates; the fields are well formed with exactly one comma fewer
	// than there are fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comma_q <= '0;
		end else if (field_ctl.frame_start) begin
			comma_q <= '0;
		end else if (field_ctl.comma_en && (comma_q != acfd_pkg::COMMA_MAX)) begin
			comma_q <= comma_q + 3'd1;
		end
	end

	assign fields_valid = (comma_q == acfd_pkg::COMMA_EXPECT);

	// Each accumulator takes digits while the comma count points at it; times ten
	// is two shifts and an add, wrapping at 16 bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < acfd_pkg::FIELD_COUNT; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < acfd_pkg::FIELD_COUNT; i++) begin
				if (field_ctl.frame_start) begin
					acc_q[i] <= '0;
				end else if (field_ctl.digit_en && (comma_q == 3'(i))) begin
					acc_q[i] <= (acc_q[i] << 3) + (acc_q[i] << 1) + {12'd0, digit};
				end
			end
		end
	end

	// Value slots without an accumulator read as zero.
	for (genvar j = 0; j < acfd_pkg::NUM_VALUES; j++) begin : g_value
		if (j < acfd_pkg::FIELD_COUNT) begin : g_acc
			assign values[j] = acc_q[j];
		end else begin : g_zero
			assign values[j] = '0;
		end
	end

endmodule

### design/ascii_command_frame_decoder.sv
// Top level of the ASCII command frame decoder: byte register, sequencer,
// field accumulators and result register. Depends on acfd_pkg and acfd_channels_if.
`timescale 1ns / 1ps

// Channel  Dir  Payload                                    Accepted when
// rx       in   rx_byte                                    rx.valid & rx.ready
// cmd      out  command, arg_is_one, four values, valid    cmd.valid & cmd.ready
//
// One byte per cycle sustained. A byte is decoded against the frame state while it
// sits in the byte register; a request appears on cmd the cycle after the closing LF
// is decoded. The byte register stalls only while a request waits in the result
// register. rx.ready stays low during reset and the cycle after.
module ascii_command_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	acfd_rx_if.sink     rx,
	acfd_cmd_if.source  cmd
);

	logic                                   init_q;
	logic                                   vld_s1;
	acfd_pkg::char_t                        rx_s1;
	logic                                   out_vld_q;
	acfd_pkg::result_t                      result_q;

	logic                                   accept;
	logic                                   fire;
	logic                                   done;
	logic                                   arg_is_one;
	logic                                   fields_valid;
	logic                                   is_att;
	acfd_pkg::cmd_t                         command;
	acfd_pkg::field_ctl_t                   field_ctl;
	logic [acfd_pkg::NUM_VALUES-1:0][15:0]  values;
	acfd_pkg::result_t                      result_d;

	// Handshake: the byte register is decoded whenever the result register can take
	// what it yields.
	assign fire     = vld_s1 && (!out_vld_q || cmd.ready);
	assign rx.ready = init_q && (!vld_s1 || fire);
	assign accept   = rx.valid && rx.ready;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= 1'b0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			init_q <= 1'b1;
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire) begin
				out_vld_q <= done;
			end else if (cmd.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			rx_s1 <= rx.rx_byte;
		end
		if (fire && done) begin
			result_q <= result_d;
		end
	end

	acfd_frame_ctl u_frame_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.rx_byte    (rx_s1),
		.field_ctl  (field_ctl),
		.done       (done),
		.command    (command),
		.arg_is_one (arg_is_one)
	);

	acfd_fields u_fields (
		.clk          (clk),
		.arst_n       (arst_n),
		.field_ctl    (field_ctl),
		.digit        (rx_s1[3:0]),
		.values       (values),
		.fields_valid (fields_valid)
	);

	// Only an attitude command carries values.
	assign is_att = (command == acfd_pkg::CMD_ATTITUDE);

	always_comb begin
		result_d.command      = command;
		result_d.arg_is_one   = arg_is_one;
		result_d.roll_value   = is_att ? values[0] : '0;
		result_d.pitch_value  = is_att ? values[1] : '0;
		result_d.yaw_value    = is_att ? values[2] : '0;
		result_d.thrust_value = is_att ? values[3] : '0;
		result_d.fields_valid = is_att && fields_valid;
	end

	// Output channel.
	assign cmd.valid        = out_vld_q;
	assign cmd.command      = result_q.command;
	assign cmd.arg_is_one   = result_q.arg_is_one;
	assign cmd.roll_value   = result_q.roll_value;
	assign cmd.pitch_value  = result_q.pitch_value;
	assign cmd.yaw_value    = result_q.yaw_value;
	assign cmd.thrust_value = result_q.thrust_value;
	assign cmd.fields_valid = result_q.fields_valid;

endmodule

### design/acfd_checker.sv
// Port-level checker of the ASCII command frame decoder, bound to the top level.
// Depends on acfd_pkg and ascii_command_frame_decoder_assert.svh.
`timescale 1ns / 1ps
`include "ascii_command_frame_decoder_assert.svh"

module acfd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             rx_valid,
	input logic             rx_ready,
	input acfd_pkg::char_t  rx_byte,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input logic [2:0]       command,
	input logic             arg_is_one,
	input acfd_pkg::value_t roll_value,
	input acfd_pkg::value_t pitch_value,
	input acfd_pkg::value_t yaw_value,
	input acfd_pkg::value_t thrust_value,
	input logic             fields_valid
);

	logic [69:0] cmd_bits;
	logic        no_values;
	logic        lf_taken;

	assign cmd_bits  = {command, arg_is_one, roll_value, pitch_value, yaw_value,
		thrust_value, fields_valid};
	assign no_values = (roll_value == '0) && (pitch_value == '0) && (yaw_value == '0)
		&& (thrust_value == '0) && !fields_valid;
	assign lf_taken  = rx_valid && rx_ready && (rx_byte == acfd_pkg::CHAR_LF);

	// A waiting request holds still until taken.
	`ACFD_ASSERT_HOLD(a_cmd_hold, clk, arst_n, cmd_valid, cmd_ready, cmd_bits, "cmd request changed while stalled")

	// Values and the field flag belong to attitude requests only.
	`ACFD_ASSERT(a_values_att_only, clk, arst_n, cmd_valid && (command != acfd_pkg::CMD_ATTITUDE) |-> no_values, "values on a non-attitude request")

	// A request after an empty output follows the taken closing LF through the byte and output valid registers.
	`ACFD_ASSERT(a_req_after_lf, clk, arst_n, $rose(cmd_valid) |-> $past(lf_taken, 2), "request without a closing LF")

endmodule

bind ascii_command_frame_decoder acfd_checker u_acfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_valid     (rx.valid),
	.rx_ready     (rx.ready),
	.rx_byte      (rx.rx_byte),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.command      (cmd.command),
	.arg_is_one   (cmd.arg_is_one),
	.roll_value   (cmd.roll_value),
	.pitch_value  (cmd.pitch_value),
	.yaw_value    (cmd.yaw_value),
	.thrust_value (cmd.thrust_value),
	.fields_valid (cmd.fields_valid)
);

### tb/acfd_decode_monitor.sv
// Monitor of the ASCII command frame decoder: watches both channels, predicts the decoded
// command requests and compares them with what the block hands out.
// Depends on acfd_pkg and the channel interfaces in acfd_channels_if.
`timescale 1ns / 1ps

module acfd_decode_monitor (
	input  logic        clk,
	input  logic        arst_n,
	acfd_rx_if          rx,
	acfd_cmd_if         cmd,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	import acfd_pkg::*;

	typedef enum logic [2:0] {
		HUNT,
		GOT_DOLLAR,
		GOT_C,
		TAG_0,
		TAG_1,
		TAG_2,
		PAYLOAD
	} frame_stage_t;

	// Known tags in command order, first received byte in the top bits.
	localparam logic [23:0] TAG_NAMES [NUM_TAGS] = '{"TAK", "THR", "HET", "LOG", "KEP", "CTL"};
	localparam int unsigned REPORT_LIMIT = 10;

	frame_stage_t stage;
	char_t        tag_bytes [HEADER_LENGTH];
	char_t        first_payload;
	logic         payload_seen;
	logic         saw_cr;
	logic         payload_done;
	logic [15:0]  field_sum [FIELD_COUNT];
	comma_cnt_t   commas;
	result_t      expected_commands [$];
	int unsigned  bad_count = 0;

	// Everything a new frame starts from.
	task automatic clear_frame();
		foreach (tag_bytes[i]) tag_bytes[i] = '0;
		foreach (field_sum[i]) field_sum[i] = '0;
		first_payload = '0;
		payload_seen  = 1'b0;
		commas        = '0;
		saw_cr        = 1'b0;
		payload_done  = 1'b0;
	endtask

	// A header byte that does not fit only restarts the header when it is a dollar sign.
	function automatic frame_stage_t header_restart(input char_t b);
		return (b == CHAR_DOLLAR) ? GOT_DOLLAR : HUNT;
	endfunction

	// The closing LF: a known tag yields one command request.
	task automatic close_frame();
		logic [23:0] tag_word;
		logic [15:0] values [4];
		result_t     r;
		int          hit;
		stage    = HUNT;
		tag_word = {tag_bytes[0], tag_bytes[1], tag_bytes[2]};
		hit      = -1;
		for (int k = 0; k < NUM_TAGS; k++) begin
			if (tag_word == TAG_NAMES[k])
				hit = k;
		end
		if (hit < 0)
			return;
		r            = '0;
		r.command    = cmd_t'(3'(hit));
		r.arg_is_one = payload_seen && first_payload == CHAR_ONE;
		if (r.command == CMD_ATTITUDE) begin
			for (int j = 0; j < 4; j++)
				values[j] = (j < FIELD_COUNT) ? field_sum[j] : 16'd0;
			r.roll_value   = value_t'(values[0]);
			r.pitch_value  = value_t'(values[1]);
			r.yaw_value    = value_t'(values[2]);
			r.thrust_value = value_t'(values[3]);
			r.fields_valid = (commas == COMMA_EXPECT);
		end
		expected_commands.push_back(r);
	endtask

	// Advance the frame state by one received byte.
	task automatic decode_rx_byte(input char_t b);
		case (stage)
			GOT_DOLLAR: stage = (b == CHAR_C) ? GOT_C : header_restart(b);
			GOT_C:      stage = (b == CHAR_M) ? TAG_0 : header_restart(b);
			TAG_0, TAG_1, TAG_2: begin
				if (saw_cr && b == CHAR_LF) begin
					stage = HUNT;
				end else begin
					tag_bytes[stage - TAG_0] = b;
					saw_cr = (b == CHAR_CR);
					stage  = frame_stage_t'(stage + 1);
				end
			end
			PAYLOAD: begin
				if (saw_cr && b == CHAR_LF) begin
					close_frame();
				end else begin
					if (!payload_seen) begin
						first_payload = b;
						payload_seen  = 1'b1;
					end
					// Fields stop at the first CR; digits past the last field are dropped.
					if (b == CHAR_CR) begin
						payload_done = 1'b1;
					end else if (!payload_done) begin
						if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
							if (commas < FIELD_COUNT)
								field_sum[commas] = field_sum[commas] * 16'd10 +
									16'(b - CHAR_ZERO);
						end else if (b == CHAR_COMMA && commas != COMMA_MAX) begin
							commas = commas + 1'b1;
						end
					end
					saw_cr = (b == CHAR_CR);
				end
			end
			default: begin
				if (b == CHAR_DOLLAR) begin
					clear_frame();
					stage = GOT_DOLLAR;
				end else begin
					stage = HUNT;
				end
			end
		endcase
	endtask

	task automatic note_mismatch(input string what, input result_t want, input logic has_want);
		bad_count++;
		if (bad_count <= REPORT_LIMIT) begin
			$display("%0t: command mismatch, %s", $time, what);
			if (has_want)
				$display("  expected cmd=%0d arg=%0b roll=%0d pitch=%0d yaw=%0d thrust=%0d valid=%0b",
					want.command, want.arg_is_one, want.roll_value, want.pitch_value,
					want.yaw_value, want.thrust_value, want.fields_valid);
			$display("  actual   cmd=%0d arg=%0b roll=%0d pitch=%0d yaw=%0d thrust=%0d valid=%0b",
				cmd.command, cmd.arg_is_one, cmd.roll_value, cmd.pitch_value,
				cmd.yaw_value, cmd.thrust_value, cmd.fields_valid);
		end
	endtask

	// Compare one accepted command request with the oldest prediction.
	task automatic check_command();
		result_t want;
		if (expected_commands.size() == 0) begin
			note_mismatch("request with nothing predicted", '0, 1'b0);
			return;
		end
		want = expected_commands.pop_front();
		if (cmd.command !== want.command || cmd.arg_is_one !== want.arg_is_one ||
				cmd.roll_value !== want.roll_value || cmd.pitch_value !== want.pitch_value ||
				cmd.yaw_value !== want.yaw_value || cmd.thrust_value !== want.thrust_value ||
				cmd.fields_valid !== want.fields_valid)
			note_mismatch("field differs", want, 1'b1);
	endtask

	// Bytes are decoded before command requests are checked at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage = HUNT;
			clear_frame();
			expected_commands.delete();
		end else begin
			if (rx.valid === 1'b1 && rx.ready === 1'b1)
				decode_rx_byte(rx.rx_byte);
			if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
				check_command();
		end
		mismatches  <= bad_count;
		outstanding <= expected_commands.size();
	end

endmodule

### tb/testbench.sv
// Top of the ASCII command frame decoder test: clock, reset, byte stimulus and the
// command receiver. Depends on acfd_pkg, acfd_channels_if, the decoder and acfd_decode_monitor.
`timescale 1ns / 1ps

module testbench;
	import acfd_pkg::*;

	localparam int          RESET_CYCLES  = 9;
	localparam int          PHASE_BYTES   = 80;
	localparam int          PRESSURE_TAGS = 20;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int          SETTLE_CYCLES = 16;
	localparam int unsigned LIMIT_CYCLES  = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned send_gap_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic        hold_kick = 1'b0;
	logic        hold_seen = 1'b0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	char_t       byte_stream [$];
	string       tag_names [NUM_TAGS] = '{"TAK", "THR", "HET", "LOG", "KEP", "CTL"};

	acfd_rx_if  rx ();
	acfd_cmd_if cmd ();

	ascii_command_frame_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.cmd    (cmd)
	);

	acfd_decode_monitor decode_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.cmd         (cmd),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// A toggle of hold_kick starts a long hold-off of the command receiver.
	always @(posedge clk) begin
		if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Command receiver with random stalls.
	always @(posedge clk) begin
		cmd.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("ascii_command_frame_decoder regression: fail");
			$finish;
		end
	end

	task automatic push_byte(input char_t b);
		byte_stream.push_back(b);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			byte_stream.push_back(char_t'(s[i]));
	endtask

	task automatic push_end();
		push_byte(CHAR_CR);
		push_byte(CHAR_LF);
	endtask

	task automatic push_digits(input int unsigned count);
		repeat (count) push_byte(CHAR_ZERO + char_t'($urandom_range(9)));
	endtask

	task automatic push_letter();
		push_byte(char_t'($urandom_range(8'h41, 8'h5A)));
	endtask

	// Payload of a tag without fields: empty, a leading one, or arbitrary bytes.
	task automatic push_plain_payload();
		case ($urandom_range(3))
			0: ;
			1: begin
				push_byte(CHAR_ONE);
				repeat ($urandom_range(2)) push_byte(char_t'($urandom_range(255)));
			end
			default: begin
				repeat ($urandom_range(1, 4)) push_byte(char_t'($urandom_range(255)));
			end
		endcase
	endtask

	// Attitude payload: mostly four fields, sometimes too few or too many commas.
	task automatic push_field_payload();
		int unsigned comma_total;
		comma_total = ($urandom_range(3) != 0) ? 3 : $urandom_range(8);
		for (int unsigned i = 0; i <= comma_total; i++) begin
			if ($urandom_range(9) == 0)
				push_text("-");
			push_digits(($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(4));
			if (i < comma_total)
				push_byte(CHAR_COMMA);
		end
		if ($urandom_range(5) == 0) begin
			push_byte(CHAR_CR);
			push_digits(2);
			push_byte(CHAR_COMMA);
		end
	endtask

	// One random frame, broken frame or burst of noise.
	task automatic push_random_frame();
		int unsigned pick;
		int unsigned k;
		pick = $urandom_range(99);
		if (pick < 72) begin
			k = $urandom_range(NUM_TAGS - 1);
			push_text("$CM");
			push_text(tag_names[k]);
			if (k == int'(CMD_ATTITUDE))
				push_field_payload();
			else
				push_plain_payload();
			push_end();
		end else if (pick < 80) begin
			push_text("$CM");
			repeat (3) push_letter();
			push_plain_payload();
			push_end();
		end else if (pick < 88) begin
			push_byte(CHAR_DOLLAR);
			if ($urandom_range(1))
				push_byte(CHAR_C);
			push_byte(char_t'($urandom_range(255)));
			push_text("TAK1");
			push_end();
		end else if (pick < 93) begin
			push_text("$CM");
			repeat ($urandom_range(2)) push_letter();
			push_end();
		end else begin
			repeat ($urandom_range(1, 6)) push_byte(char_t'($urandom_range(255)));
		end
	endtask

	// Offer every queued byte as a request, with random gaps.
	task automatic send_stream();
		while (byte_stream.size() != 0) begin
			while ($urandom_range(99) < send_gap_pct) begin
				rx.valid <= 1'b0;
				@(posedge clk);
			end
			rx.valid   <= 1'b1;
			rx.rx_byte <= byte_stream.pop_front();
			do @(posedge clk); while (rx.ready !== 1'b1);
		end
	endtask

	task automatic run_phase(input int unsigned gap_pct, input int unsigned stall_pct);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		while (byte_stream.size() < PHASE_BYTES)
			push_random_frame();
		send_stream();
	endtask

	initial begin
		rx.valid   = 1'b0;
		rx.rx_byte = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: every tag, the header and payload corner cases, byte extremes.
		push_byte(8'h00);
		push_byte(8'hFF);
		push_text("$CMTAK1");
		push_end();
		push_text("$CMTHR");
		push_end();
		push_text("$CMHET0");
		push_end();
		push_text("$CMLOG1x$");
		push_end();
		push_text("$CMKEP");
		push_byte(8'hFF);
		push_byte(8'h00);
		push_end();
		push_text("$CMCTL1500,20,30,1700");
		push_end();
		push_text("$CMCTL32767,32768,65535,99999");
		push_end();
		push_text("$CMCTL1,2,3,4,5,6,7,8,9");
		push_end();
		push_text("$CMCTL12,34");
		push_end();
		push_text("$CMCTL1,2,3,4");
		push_byte(CHAR_CR);
		push_text("55,6");
		push_end();
		push_text("$C$CMTAK1");
		push_end();
		push_text("$CXTAK1");
		push_end();
		push_text("$CMT");
		push_end();
		push_text("$CMAB");
		push_end();
		push_text("$CMABC1");
		push_end();
		push_text("$CMTAK$CM1");
		push_end();
		push_end();
		send_stream();

		// Receiver holds off while short frames keep coming, so the decoder backs up.
		hold_kick <= ~hold_kick;
		repeat (PRESSURE_TAGS) begin
			push_text("$CM");
			push_text(tag_names[$urandom_range(NUM_TAGS - 1)]);
			push_byte(CHAR_ONE);
			push_end();
		end
		send_stream();

		// Random frames under each idling pattern.
		run_phase(0, 0);
		run_phase(74, 0);
		run_phase(0, 74);
		run_phase(28, 28);
		rx.valid <= 1'b0;

		// Drain the outstanding command requests, then let the pipeline settle.
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ascii_command_frame_decoder regression: pass");
		else
			$display("ascii_command_frame_decoder regression: fail");
		$finish;
	end

endmodule
